// ===== rtl/i2cms_pkg.sv =====
`default_nettype none

package i2cms_pkg;

  // default width of the transfer byte counter
  localparam int unsigned CountBitsDefault = 16;

  // request opcodes
  localparam logic [1:0] OP_READ  = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_EVENT = 2'd2;
  localparam logic [1:0] OP_ERROR = 2'd3;

  // peripheral event flag positions
  localparam int unsigned EV_SB   = 0;
  localparam int unsigned EV_ADDR = 1;
  localparam int unsigned EV_TXE  = 2;
  localparam int unsigned EV_RXNE = 3;
  localparam int unsigned EV_BTF  = 4;

  // error flag positions
  localparam int unsigned ER_NACK    = 0;
  localparam int unsigned ER_BUS     = 1;
  localparam int unsigned ER_ARLO    = 2;
  localparam int unsigned ER_OVR     = 3;
  localparam int unsigned ER_TIMEOUT = 4;

  // error codes
  localparam logic [1:0] ERR_NONE     = 2'd0;
  localparam logic [1:0] ERR_NACK     = 2'd1;
  localparam logic [1:0] ERR_RECOVERY = 2'd2;
  localparam logic [1:0] ERR_TIMEOUT  = 2'd3;

  // ack and interrupt control codes
  localparam logic [1:0] CTL_KEEP    = 2'd0;
  localparam logic [1:0] CTL_ENABLE  = 2'd1;
  localparam logic [1:0] CTL_DISABLE = 2'd2;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_START     = 3'd1,
    PH_SADDR     = 3'd2,
    PH_SEND_REG  = 3'd3,
    PH_SEND_DATA = 3'd4,
    PH_RESTART   = 3'd5,
    PH_READ_DATA = 3'd6,
    PH_DATA_SENT = 3'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [6:0]  slave_addr;
    logic [7:0]  reg_addr;
    logic [15:0] byte_count;
    logic [7:0]  tx_byte;
    logic [7:0]  rx_byte;
    logic [4:0]  event_flags;
    logic [4:0]  error_flags;
  } in_t;

  typedef struct packed {
    logic       send_valid;
    logic [7:0] send_value;
    logic       store_valid;
    logic [7:0] store_value;
    logic       tx_taken;
    logic       start_request;
    logic       stop_request;
    logic [1:0] ack_control;
    logic [1:0] irq_control;
    logic       reset_request;
    logic [1:0] error_code;
    logic       busy_res;
  } out_t;

endpackage

`default_nettype wire

// ===== rtl/i2c_master_register_sequencer.sv =====
`default_nettype none

// i2c master register read/write sequencer. each request is a command (read or
// write: slave address, register address, byte count) or a peripheral event or
// error event; every request yields exactly one result telling the peripheral
// driver what to do next (byte to send, byte to store, start/stop/ack/irq
// control, abort) plus the last error code and whether a transfer is still
// running. one request is accepted per clock while in_stall is low: the transfer
// state is registered at the accepting edge, and so is the result, in the result
// register, or in the skid register while the result register holds a result
// not yet taken. a two-entry output stage (result register plus skid register)
// lets requests keep flowing while a result waits; in_stall rises only once
// both entries are full. a command while busy replaces the running transfer,
// and any error event ends the transfer and returns the block to idle.
module i2c_master_register_sequencer #(
  parameter int unsigned COUNT_BITS = i2cms_pkg::CountBitsDefault
) (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  output logic            in_stall,
  input  i2cms_pkg::in_t  in_data,
  output logic            out_valid,
  input  wire             out_stall,
  output i2cms_pkg::out_t out_data
);

  // transfer state
  i2cms_pkg::phase_t     phase_r, phase_nxt;
  logic                  read_addr_phase_r, read_addr_phase_nxt;
  logic                  reg_sent_r, reg_sent_nxt;
  logic                  is_read_r, is_read_nxt;
  logic [6:0]            target_addr_r, target_addr_nxt;
  logic [7:0]            target_reg_r, target_reg_nxt;
  logic [COUNT_BITS-1:0] bytes_left_r, bytes_left_nxt;
  logic [1:0]            last_error_r, last_error_nxt;

  // output stage
  logic            out_valid_r, skid_valid_r;
  i2cms_pkg::out_t out_data_r, skid_data_r;
  i2cms_pkg::out_t res;

  logic                  in_accept, out_take;
  logic [COUNT_BITS-1:0] bytes_dec;
  logic                  left_is_one, left_is_zero;
  logic [1:0]            err_code;
  logic                  send_abort;

  assign in_stall  = skid_valid_r;
  assign in_accept = in_valid & ~skid_valid_r;
  assign out_take  = out_valid_r & ~out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign bytes_dec    = bytes_left_r - COUNT_BITS'(1);
  assign left_is_one  = (bytes_left_r == COUNT_BITS'(1));
  assign left_is_zero = (bytes_left_r == '0);

  // error ranking: timeout, then recovery class, then nack
  always_comb begin
    err_code   = i2cms_pkg::ERR_RECOVERY;
    send_abort = 1'b1;
    if (in_data.error_flags[i2cms_pkg::ER_NACK]) begin
      err_code = i2cms_pkg::ERR_NACK;
    end
    if (in_data.error_flags[i2cms_pkg::ER_BUS] || in_data.error_flags[i2cms_pkg::ER_OVR]) begin
      err_code = i2cms_pkg::ERR_RECOVERY;
    end
    if (in_data.error_flags[i2cms_pkg::ER_ARLO]) begin
      err_code   = i2cms_pkg::ERR_RECOVERY;
      send_abort = 1'b0;  // lost the bus, no abort
    end
    if (in_data.error_flags[i2cms_pkg::ER_TIMEOUT]) begin
      err_code = i2cms_pkg::ERR_TIMEOUT;
    end
  end

  // next state and result for the request on the input
  always_comb begin
    phase_nxt           = phase_r;
    read_addr_phase_nxt = read_addr_phase_r;
    reg_sent_nxt        = reg_sent_r;
    is_read_nxt         = is_read_r;
    target_addr_nxt     = target_addr_r;
    target_reg_nxt      = target_reg_r;
    bytes_left_nxt      = bytes_left_r;
    last_error_nxt      = last_error_r;
    res                 = '0;

    unique case (in_data.op)
      i2cms_pkg::OP_READ, i2cms_pkg::OP_WRITE: begin
        // latch the command and ask for START
        target_addr_nxt     = in_data.slave_addr;
        target_reg_nxt      = in_data.reg_addr;
        bytes_left_nxt      = COUNT_BITS'(in_data.byte_count);
        is_read_nxt         = (in_data.op == i2cms_pkg::OP_READ);
        phase_nxt           = i2cms_pkg::PH_START;
        read_addr_phase_nxt = 1'b0;
        reg_sent_nxt        = 1'b0;
        res.irq_control     = i2cms_pkg::CTL_ENABLE;
        res.start_request   = 1'b1;
      end
      i2cms_pkg::OP_EVENT: begin
        // only the highest priority flag is handled
        if (in_data.event_flags[i2cms_pkg::EV_SB]) begin
          if (phase_r == i2cms_pkg::PH_START) begin
            read_addr_phase_nxt = 1'b0;
            res.send_valid      = 1'b1;
            res.send_value      = {target_addr_r, 1'b0};
            phase_nxt           = i2cms_pkg::PH_SADDR;
          end else if (phase_r == i2cms_pkg::PH_RESTART) begin
            read_addr_phase_nxt = 1'b1;
            res.send_valid      = 1'b1;
            res.send_value      = {target_addr_r, 1'b1};
            phase_nxt           = i2cms_pkg::PH_SADDR;
          end
        end else if (in_data.event_flags[i2cms_pkg::EV_ADDR]) begin
          if (phase_r == i2cms_pkg::PH_SADDR && !read_addr_phase_r) begin
            phase_nxt = is_read_r ? i2cms_pkg::PH_SEND_REG : i2cms_pkg::PH_SEND_DATA;
          end else if (phase_r == i2cms_pkg::PH_SADDR && is_read_r) begin
            phase_nxt = i2cms_pkg::PH_READ_DATA;
            if (left_is_one) begin
              res.ack_control = i2cms_pkg::CTL_DISABLE;
            end else if (!left_is_zero) begin
              res.ack_control = i2cms_pkg::CTL_ENABLE;
            end
          end
        end else if (in_data.event_flags[i2cms_pkg::EV_TXE]) begin
          if (phase_r == i2cms_pkg::PH_SEND_REG || phase_r == i2cms_pkg::PH_SEND_DATA) begin
            if (!reg_sent_r) begin
              res.send_valid = 1'b1;
              res.send_value = target_reg_r;
              reg_sent_nxt   = 1'b1;
            end else if (phase_r == i2cms_pkg::PH_SEND_REG) begin
              // register byte done on a read: repeated start
              res.start_request = 1'b1;
              phase_nxt         = i2cms_pkg::PH_RESTART;
            end else begin
              if (!left_is_zero) begin
                res.send_valid = 1'b1;
                res.send_value = in_data.tx_byte;
                res.tx_taken   = 1'b1;
                bytes_left_nxt = bytes_dec;
              end
              if (left_is_zero || left_is_one) begin
                phase_nxt = i2cms_pkg::PH_DATA_SENT;
              end
            end
          end
        end else if (in_data.event_flags[i2cms_pkg::EV_RXNE]) begin
          if (phase_r == i2cms_pkg::PH_READ_DATA) begin
            if (left_is_one) begin
              // last byte: stop and go idle
              res.stop_request = 1'b1;
              res.store_valid  = 1'b1;
              res.store_value  = in_data.rx_byte;
              bytes_left_nxt   = '0;
              phase_nxt        = i2cms_pkg::PH_IDLE;
              res.irq_control  = i2cms_pkg::CTL_DISABLE;
            end else if (!left_is_zero) begin
              bytes_left_nxt  = bytes_dec;
              res.store_valid = 1'b1;
              res.store_value = in_data.rx_byte;
              if (bytes_dec == COUNT_BITS'(1)) begin
                res.ack_control = i2cms_pkg::CTL_DISABLE;  // nack the final byte
              end
            end
          end
        end else if (in_data.event_flags[i2cms_pkg::EV_BTF]) begin
          if (phase_r == i2cms_pkg::PH_DATA_SENT) begin
            res.stop_request = 1'b1;
            phase_nxt        = i2cms_pkg::PH_IDLE;
            res.irq_control  = i2cms_pkg::CTL_DISABLE;
          end
        end
      end
      i2cms_pkg::OP_ERROR: begin
        // errors while idle are dropped
        if (phase_r != i2cms_pkg::PH_IDLE) begin
          last_error_nxt    = err_code;
          res.reset_request = send_abort;
          phase_nxt         = i2cms_pkg::PH_IDLE;
        end
      end
      default: begin
      end
    endcase

    res.error_code = last_error_nxt;
    res.busy_res   = (phase_nxt != i2cms_pkg::PH_IDLE);
  end

  // transfer state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r           <= i2cms_pkg::PH_IDLE;
      read_addr_phase_r <= 1'b0;
      reg_sent_r        <= 1'b0;
      is_read_r         <= 1'b0;
      target_addr_r     <= '0;
      target_reg_r      <= '0;
      bytes_left_r      <= '0;
      last_error_r      <= i2cms_pkg::ERR_NONE;
    end else if (in_accept) begin
      phase_r           <= phase_nxt;
      read_addr_phase_r <= read_addr_phase_nxt;
      reg_sent_r        <= reg_sent_nxt;
      is_read_r         <= is_read_nxt;
      target_addr_r     <= target_addr_nxt;
      target_reg_r      <= target_reg_nxt;
      bytes_left_r      <= bytes_left_nxt;
      last_error_r      <= last_error_nxt;
    end
  end

  // output register plus skid entry, results stay in order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (skid_valid_r) begin
        // no new request while the skid entry is full
        if (out_take) begin
          out_valid_r  <= 1'b1;
          skid_valid_r <= 1'b0;
        end
      end else if (in_accept) begin
        if (!out_valid_r || out_take) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_take) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_take) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_accept) begin
      if (!out_valid_r || out_take) begin
        out_data_r <= res;
      end else begin
        skid_data_r <= res;
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/i2cms_checker.sv =====
`timescale 1ns / 1ps

module i2cms_checker (
  input  wire             clk,
  input  wire             rst_n,
  input  wire             in_valid,
  input  wire             in_stall,
  input  i2cms_pkg::in_t  in_data,
  input  wire             out_valid,
  input  wire             out_stall,
  input  i2cms_pkg::out_t out_data,
  output int unsigned     mismatches,
  output int unsigned     outstanding
);
  import i2cms_pkg::*;

  // transfer state of the sequencer as predicted
  phase_t      seq_phase;
  logic        sla_read;
  logic        reg_done;
  logic        rd_xfer;
  logic [6:0]  sla;
  logic [7:0]  reg_index;
  logic [15:0] remaining;
  logic [1:0]  err_last;

  out_t        pending_results[$];
  int unsigned bad_count = 0;

  task automatic advance_sequencer(input in_t req, output out_t res);
    logic [1:0] code;
    logic       abort;
    res = '0;
    case (req.op)
      OP_READ, OP_WRITE: begin
        sla       = req.slave_addr;
        reg_index = req.reg_addr;
        remaining = req.byte_count;
        rd_xfer   = (req.op == OP_READ);
        seq_phase = PH_START;
        sla_read  = 1'b0;
        reg_done  = 1'b0;
        res.irq_control   = CTL_ENABLE;
        res.start_request = 1'b1;
      end
      OP_EVENT: begin
        if (req.event_flags[EV_SB]) begin
          if (seq_phase == PH_START || seq_phase == PH_RESTART) begin
            sla_read       = (seq_phase == PH_RESTART);
            res.send_valid = 1'b1;
            res.send_value = {sla, sla_read};
            seq_phase      = PH_SADDR;
          end
        end else if (req.event_flags[EV_ADDR]) begin
          if (seq_phase == PH_SADDR && !sla_read) begin
            seq_phase = rd_xfer ? PH_SEND_REG : PH_SEND_DATA;
          end else if (seq_phase == PH_SADDR && rd_xfer) begin
            seq_phase = PH_READ_DATA;
            if (remaining == 16'd1) res.ack_control = CTL_DISABLE;
            else if (remaining > 16'd1) res.ack_control = CTL_ENABLE;
          end
        end else if (req.event_flags[EV_TXE]) begin
          if (seq_phase == PH_SEND_REG || seq_phase == PH_SEND_DATA) begin
            if (!reg_done) begin
              res.send_valid = 1'b1;
              res.send_value = reg_index;
              reg_done       = 1'b1;
            end else if (seq_phase == PH_SEND_REG) begin
              res.start_request = 1'b1;
              seq_phase         = PH_RESTART;
            end else begin
              if (remaining != 16'd0) begin
                res.send_valid = 1'b1;
                res.send_value = req.tx_byte;
                res.tx_taken   = 1'b1;
                remaining      = remaining - 16'd1;
              end
              if (remaining == 16'd0) seq_phase = PH_DATA_SENT;
            end
          end
        end else if (req.event_flags[EV_RXNE]) begin
          if (seq_phase == PH_READ_DATA && remaining != 16'd0) begin
            res.store_valid = 1'b1;
            res.store_value = req.rx_byte;
            if (remaining == 16'd1) begin
              res.stop_request = 1'b1;
              res.irq_control  = CTL_DISABLE;
              remaining        = 16'd0;
              seq_phase        = PH_IDLE;
            end else begin
              remaining = remaining - 16'd1;
              if (remaining == 16'd1) res.ack_control = CTL_DISABLE;
            end
          end
        end else if (req.event_flags[EV_BTF]) begin
          if (seq_phase == PH_DATA_SENT) begin
            res.stop_request = 1'b1;
            res.irq_control  = CTL_DISABLE;
            seq_phase        = PH_IDLE;
          end
        end
      end
      OP_ERROR: begin
        // timeout outranks recovery causes, which outrank nack
        code  = ERR_RECOVERY;
        abort = 1'b1;
        if (req.error_flags[ER_NACK]) code = ERR_NACK;
        if (req.error_flags[ER_BUS] || req.error_flags[ER_OVR]) code = ERR_RECOVERY;
        if (req.error_flags[ER_ARLO]) begin
          code  = ERR_RECOVERY;
          abort = 1'b0;
        end
        if (req.error_flags[ER_TIMEOUT]) code = ERR_TIMEOUT;
        if (seq_phase != PH_IDLE) begin
          err_last          = code;
          res.reset_request = abort;
          seq_phase         = PH_IDLE;
        end
      end
    endcase
    res.error_code = err_last;
    res.busy_res   = (seq_phase != PH_IDLE);
  endtask

  always @(posedge clk) begin
    out_t  want;
    out_t  got;
    string diff;
    if (!rst_n) begin
      seq_phase = PH_IDLE;
      sla_read  = 1'b0;
      reg_done  = 1'b0;
      rd_xfer   = 1'b0;
      sla       = '0;
      reg_index = '0;
      remaining = '0;
      err_last  = ERR_NONE;
      pending_results.delete();
    end else begin
      if (in_valid && !in_stall) begin
        advance_sequencer(in_data, want);
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = out_data;
        if (pending_results.size() == 0) begin
          if (bad_count < 10) $display("unexpected result %h with nothing pending", got);
          bad_count++;
        end else begin
          want = pending_results.pop_front();
          diff = "";
          if (got.send_valid !== want.send_valid) diff = {diff, " send_valid"};
          if (got.send_value !== want.send_value) diff = {diff, " send_value"};
          if (got.store_valid !== want.store_valid) diff = {diff, " store_valid"};
          if (got.store_value !== want.store_value) diff = {diff, " store_value"};
          if (got.tx_taken !== want.tx_taken) diff = {diff, " tx_taken"};
          if (got.start_request !== want.start_request) diff = {diff, " start_request"};
          if (got.stop_request !== want.stop_request) diff = {diff, " stop_request"};
          if (got.ack_control !== want.ack_control) diff = {diff, " ack_control"};
          if (got.irq_control !== want.irq_control) diff = {diff, " irq_control"};
          if (got.reset_request !== want.reset_request) diff = {diff, " reset_request"};
          if (got.error_code !== want.error_code) diff = {diff, " error_code"};
          if (got.busy_res !== want.busy_res) diff = {diff, " busy_res"};
          if (diff != "") begin
            if (bad_count < 10) begin
              $display("result mismatch in%s: expected %h actual %h", diff, want, got);
            end
            bad_count++;
          end
        end
      end
    end
    mismatches  <= bad_count;
    outstanding <= pending_results.size();
  end

endmodule

// ===== tb/i2c_master_register_sequencer_tb.sv =====
`timescale 1ns / 1ps

module i2c_master_register_sequencer_tb;
  import i2cms_pkg::*;

  // request index at which the sender waits for every result to drain
  localparam int unsigned PauseAt    = 700;
  // accepted requests before the receiver's long hold-off, and its length
  localparam int unsigned HoldAt     = 400;
  localparam int unsigned HoldCycles = 120;
  // random requests on top of the directed ones
  localparam int unsigned RandomReqs = 1200;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_t         in_data;
  logic        out_valid;
  logic        out_stall;
  out_t        out_data;
  int unsigned mismatches;
  int unsigned outstanding;

  in_t         stim_q[$];
  int unsigned accepted_cnt = 0;

  i2c_master_register_sequencer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // predicts every accepted request and compares the results in order
  i2cms_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_data     (in_data),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // hard limit, far beyond the slowest legal run
  initial begin
    #10_000_000;
    $display("[i2c_master_register_sequencer] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // request builders
  // ---------------------------------------------------------------------------

  function automatic in_t mk_req(logic [1:0] op, logic [6:0] sa, logic [7:0] ra,
                                 logic [15:0] cnt, logic [7:0] txb, logic [7:0] rxb,
                                 logic [4:0] ev, logic [4:0] er);
    in_t r;
    r.op          = op;
    r.slave_addr  = sa;
    r.reg_addr    = ra;
    r.byte_count  = cnt;
    r.tx_byte     = txb;
    r.rx_byte     = rxb;
    r.event_flags = ev;
    r.error_flags = er;
    return r;
  endfunction

  // every field random, any opcode
  function automatic in_t rand_req();
    in_t r;
    r.op          = 2'($urandom_range(0, 3));
    r.slave_addr  = 7'($urandom);
    r.reg_addr    = 8'($urandom);
    r.byte_count  = 16'($urandom);
    r.tx_byte     = 8'($urandom);
    r.rx_byte     = 8'($urandom);
    r.event_flags = 5'($urandom);
    r.error_flags = 5'($urandom);
    return r;
  endfunction

  // peripheral event whose top-priority flag is bit_idx; lower-priority
  // flags are sometimes set too, they must be ignored
  function automatic in_t event_req(int unsigned bit_idx);
    in_t        r;
    logic [4:0] hit;
    logic [4:0] lower_prio;
    r          = rand_req();
    hit        = 5'd1 << bit_idx;
    lower_prio = ~((hit << 1) - 5'd1);
    r.op       = OP_EVENT;
    r.event_flags = hit | (($urandom_range(0, 1) != 0) ? (r.event_flags & lower_prio) : 5'd0);
    return r;
  endfunction

  function automatic in_t error_req();
    in_t r;
    r    = rand_req();
    r.op = OP_ERROR;
    return r;
  endfunction

  function automatic in_t command_req(logic [1:0] op, logic [15:0] cnt);
    in_t r;
    r            = rand_req();
    r.op         = op;
    r.byte_count = cnt;
    return r;
  endfunction

  // one read or write transfer with random content; mostly well-formed, some
  // cut short and ended by an error or a stray request
  task automatic queue_transfer(input bit rd);
    in_t         seq[$];
    int unsigned cnt;
    int unsigned n_data;
    int unsigned cut;
    int unsigned pick;
    bit          whole;
    pick = $urandom_range(0, 9);
    if (pick < 7) cnt = $urandom_range(0, 4);
    else if (pick < 9) cnt = $urandom_range(5, 12);
    else cnt = $urandom_range(13, 65535);
    // huge counts only get a few bytes before being torn down
    whole  = (cnt <= 12);
    n_data = whole ? cnt : 3;
    seq.push_back(command_req(rd ? OP_READ : OP_WRITE, 16'(cnt)));
    seq.push_back(event_req(EV_SB));
    seq.push_back(event_req(EV_ADDR));
    seq.push_back(event_req(EV_TXE));
    if (rd) begin
      // register byte done, repeated start, then address with read bit
      seq.push_back(event_req(EV_TXE));
      seq.push_back(event_req(EV_SB));
      seq.push_back(event_req(EV_ADDR));
      repeat (n_data) seq.push_back(event_req(EV_RXNE));
      // a zero-byte read only ends through an error
      if (cnt == 0) whole = 1'b0;
    end else begin
      repeat ((n_data == 0) ? 1 : n_data) seq.push_back(event_req(EV_TXE));
      if (whole) seq.push_back(event_req(EV_BTF));
    end
    if (!whole || $urandom_range(0, 4) == 0) begin
      if (whole) begin
        cut = $urandom_range(1, seq.size() - 1);
        seq = seq[0:cut-1];
      end
      if ($urandom_range(0, 2) != 0) seq.push_back(error_req());
      else seq.push_back(rand_req());
    end
    foreach (seq[i]) stim_q.push_back(seq[i]);
  endtask

  task automatic build_stimulus();
    int unsigned target;
    // write of one byte at the top addresses, all event flags on the start
    stim_q.push_back(mk_req(OP_WRITE, 7'h7f, 8'hff, 16'd1, 8'h00, 8'h00, 5'h00, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h1f, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h1e, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h1c, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'hff, 8'h00, 5'h04, 5'h1f));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h10, 5'h00));
    // two-byte read at the bottom addresses: ack on, then off, then stop
    stim_q.push_back(mk_req(OP_READ, 7'h00, 8'h00, 16'd2, 8'h00, 8'h00, 5'h00, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h01, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h02, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h04, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h0c, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h01, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h02, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'hff, 5'h18, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h08, 5'h00));
    // zero-byte write: stop right after the register byte
    stim_q.push_back(mk_req(OP_WRITE, 7'h55, 8'haa, 16'd0, 8'h00, 8'h00, 5'h00, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h01, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h02, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h04, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h5a, 8'h00, 5'h04, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h10, 5'h00));
    // error while idle is ignored
    stim_q.push_back(mk_req(OP_ERROR, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h00, 5'h1f));
    // max count read, no event flags, then an error with no flag set
    stim_q.push_back(mk_req(OP_READ, 7'h2a, 8'h3c, 16'hffff, 8'h00, 8'h00, 5'h00, 5'h00));
    stim_q.push_back(mk_req(OP_EVENT, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h00, 5'h00));
    stim_q.push_back(mk_req(OP_ERROR, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h00, 5'h00));
    // arbitration loss with nack: recovery but no abort
    stim_q.push_back(mk_req(OP_WRITE, 7'h01, 8'h80, 16'd3, 8'h00, 8'h00, 5'h00, 5'h00));
    stim_q.push_back(mk_req(OP_ERROR, 7'h00, 8'h00, 16'd0, 8'h00, 8'h00, 5'h00, 5'h05));

    target = stim_q.size() + RandomReqs;
    while (stim_q.size() < target) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5, 6: queue_transfer($urandom_range(0, 1));
        7:       repeat ($urandom_range(1, 4)) stim_q.push_back(rand_req());
        8:       stim_q.push_back(error_req());
        default: stim_q.push_back(event_req($urandom_range(0, 4)));
      endcase
    end
  endtask

  // ---------------------------------------------------------------------------
  // sender: bursts of requests with random gaps, one pause until drained
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned idx;
    int unsigned burst;
    int unsigned gap;
    rst_n    <= 1'b0;
    in_valid <= 1'b0;
    in_data  <= '0;
    build_stimulus();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    idx = 0;
    while (idx < stim_q.size()) begin
      // now and then a long burst with no idling at all
      burst = ($urandom_range(0, 4) == 0) ? 60 : $urandom_range(1, 16);
      while (burst != 0 && idx < stim_q.size()) begin
        if (idx == PauseAt) begin
          // hold back until every pending result has come out
          in_valid <= 1'b0;
          @(posedge clk);
          while (outstanding != 0) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= stim_q[idx];
        @(posedge clk);
        while (in_stall) @(posedge clk);
        idx++;
        accepted_cnt = idx;
        burst--;
      end
      gap = $urandom_range(0, 6);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_valid <= 1'b0;

    // drain: wait for the last results, then a few quiet cycles
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("[i2c_master_register_sequencer] OK");
    end else begin
      $display("[i2c_master_register_sequencer] ERROR");
    end
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver: stall modes that change every so often, one long hold-off
  // ---------------------------------------------------------------------------
  initial begin
    int unsigned mode;
    int unsigned span;
    int unsigned cyc;
    bit          held;
    out_stall <= 1'b0;
    held = 1'b0;
    cyc  = 0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      repeat (span) begin
        @(posedge clk);
        cyc++;
        if (!held && accepted_cnt >= HoldAt) begin
          // long hold-off while the sender keeps offering requests,
          // so both output entries fill and in_stall rises
          held = 1'b1;
          out_stall <= 1'b1;
          repeat (HoldCycles) @(posedge clk);
        end
        case (mode)
          0:       out_stall <= 1'b0;
          1:       out_stall <= ($urandom_range(0, 3) == 0);
          2:       out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= ((cyc % 9) < 4);
        endcase
      end
    end
  end

endmodule
